// ===== sv/smbr_pkg.sv =====
// Shared types and constants for the SplitMix64 bounded random unit.
package smbr_pkg;

   localparam int WordWidth = 64;
   localparam int CountWidth = 7;

   localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;

   typedef enum logic [1:0] {
      KIND_INT  = 2'd0,
      KIND_FRAC = 2'd1,
      KIND_BIT  = 2'd2,
      KIND_SEED = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LIMIT,
      ST_LIMIT_WAIT,
      ST_MIX,
      ST_MIX_WAIT,
      ST_CHECK,
      ST_MOD,
      ST_MOD_WAIT,
      ST_FINISH,
      ST_OUT
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic       load_req;    // capture request fields
      logic       load_seed;   // state <= seed
      logic       mix_start;   // begin one sample draw
      logic       div_limit;   // start divider for rejection limit
      logic       div_sample;  // start divider for sample mod span
      logic       set_result;  // form result from sample/remainder
      logic       out_valid_set;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic     mix_done;
      logic     div_done;
      logic     span_zero;
      logic     reject;
      kind_type kind;
   } status_type;

endpackage

// ===== sv/smbr_datapath.sv =====
// Datapath: generator state, staged mixer, serial divider and result register.
module smbr_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  smbr_pkg::cmd_type     cmd,
   output smbr_pkg::status_type  status,
   input  logic [193:0]          req_tdata,
   output logic [63:0]           result
);
   import smbr_pkg::*;

   logic [1:0]  kind_ff, kind_in;
   logic [63:0] start_ff, span_ff, limit_ff;
   logic [63:0] gstate_ff, gstate_in;
   logic [63:0] z_ff;
   logic [63:0] acc_ff;
   logic [3:0]  mix_step_ff;
   logic        mix_busy_ff;
   logic        mix_done_ff;
   logic [63:0] res_ff;

   // partial product operands for the 64-bit constant multiplies
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;

   // divider state: restoring, one quotient bit per cycle
   logic [63:0] dividend_ff, rem_ff;
   logic [CountWidth-1:0] div_cnt_ff;
   logic        div_busy_ff, div_done_ff;
   logic [64:0] rem_shift;
   logic [64:0] rem_diff;

   assign kind_in = req_tdata[1:0];

   // request capture and generator state
   always_ff @(posedge clock) begin
      if (reset) begin
         gstate_ff <= '0;
      end else if (cmd.load_seed) begin
         gstate_ff <= req_tdata[193:130];
      end else if (cmd.mix_start) begin
         gstate_ff <= gstate_in;
      end
      if (cmd.load_req) begin
         kind_ff  <= kind_in;
         start_ff <= req_tdata[65:2];
         span_ff  <= req_tdata[129:66] - req_tdata[65:2];
      end
   end

   assign gstate_in = gstate_ff + GOLDEN_STEP;

   // operand select: low*low, high*low, low*high of each multiply
   always_comb begin
      mul_a = z_ff[31:0];
      mul_b = MIX_MUL_A[31:0];
      unique case (mix_step_ff)
         4'd2: mul_a = z_ff[63:32];
         4'd3: mul_b = MIX_MUL_A[63:32];
         4'd5: mul_b = MIX_MUL_B[31:0];
         4'd6: begin
            mul_a = z_ff[63:32];
            mul_b = MIX_MUL_B[31:0];
         end
         4'd7: mul_b = MIX_MUL_B[63:32];
         default: ;
      endcase
   end

   assign mul_p = 64'(mul_a) * 64'(mul_b);

   // mixer: xor-shift steps and multiplies built from 32x32 partial products
   always_ff @(posedge clock) begin
      if (reset) begin
         mix_busy_ff <= 1'b0;
         mix_done_ff <= 1'b0;
         mix_step_ff <= '0;
      end else begin
         mix_done_ff <= 1'b0;
         if (cmd.mix_start) begin
            mix_busy_ff <= 1'b1;
            mix_step_ff <= '0;
            z_ff        <= gstate_in;
         end else if (mix_busy_ff) begin
            mix_step_ff <= mix_step_ff + 4'd1;
            unique case (mix_step_ff)
               4'd0: z_ff <= z_ff ^ (z_ff >> 30);
               4'd1: acc_ff <= mul_p;
               4'd2: acc_ff[63:32] <= acc_ff[63:32] + mul_p[31:0];
               4'd3: z_ff <= {acc_ff[63:32] + mul_p[31:0], acc_ff[31:0]};
               4'd4: z_ff <= z_ff ^ (z_ff >> 27);
               4'd5: acc_ff <= mul_p;
               4'd6: acc_ff[63:32] <= acc_ff[63:32] + mul_p[31:0];
               4'd7: z_ff <= {acc_ff[63:32] + mul_p[31:0], acc_ff[31:0]};
               4'd8: begin
                  z_ff        <= z_ff ^ (z_ff >> 31);
                  mix_busy_ff <= 1'b0;
                  mix_done_ff <= 1'b1;
               end
               default: mix_busy_ff <= 1'b0;
            endcase
         end
      end
   end

   // serial divider producing remainder by span
   assign rem_shift = {rem_ff, dividend_ff[63]};
   assign rem_diff  = rem_shift - {1'b0, span_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_done_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else begin
         div_done_ff <= 1'b0;
         if (cmd.div_limit || cmd.div_sample) begin
            div_busy_ff <= 1'b1;
            div_cnt_ff  <= '0;
            rem_ff      <= '0;
            dividend_ff <= cmd.div_limit ? (64'd0 - span_ff) : z_ff;
         end else if (div_busy_ff) begin
            dividend_ff <= {dividend_ff[62:0], 1'b0};
            rem_ff <= rem_diff[64] ? rem_shift[63:0] : rem_diff[63:0];
            div_cnt_ff <= div_cnt_ff + 1'b1;
            if (div_cnt_ff == CountWidth'(WordWidth - 1)) begin
               div_busy_ff <= 1'b0;
               div_done_ff <= 1'b1;
            end
         end
      end
   end

   // limit capture and result forming
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         limit_ff <= '0;
      end else if (div_done_ff && !cmd.set_result) begin
         limit_ff <= rem_ff;
      end
      if (cmd.set_result) begin
         unique case (kind_type'(kind_ff))
            KIND_INT:  res_ff <= start_ff + ((span_ff == '0) ? z_ff : rem_ff);
            KIND_FRAC: res_ff <= {11'd0, z_ff[63:11]};
            KIND_BIT:  res_ff <= {63'd0, z_ff[0]};
            KIND_SEED: res_ff <= '0;
            default:   res_ff <= '0;
         endcase
      end
   end

   assign result           = res_ff;
   assign status.mix_done  = mix_done_ff;
   assign status.div_done  = div_done_ff;
   assign status.span_zero = (span_ff == '0);
   assign status.reject    = (z_ff < limit_ff);
   assign status.kind      = kind_type'(kind_ff);

endmodule

// ===== sv/smbr_control.sv =====
// Controller state machine sequencing draws, rejection and division.
module smbr_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [1:0]            req_kind,
   input  smbr_pkg::status_type  status,
   output smbr_pkg::cmd_type     cmd
);
   import smbr_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      accept;

   assign accept = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (kind_type'(req_kind) == KIND_SEED) state_in = ST_FINISH;
               else if (kind_type'(req_kind) == KIND_INT) state_in = ST_LIMIT;
               else state_in = ST_MIX;
            end
         end
         ST_LIMIT:      state_in = status.span_zero ? ST_MIX : ST_LIMIT_WAIT;
         ST_LIMIT_WAIT: if (status.div_done) state_in = ST_MIX;
         ST_MIX:        state_in = ST_MIX_WAIT;
         ST_MIX_WAIT:   if (status.mix_done) state_in = ST_CHECK;
         ST_CHECK: begin
            if (status.kind != KIND_INT || status.span_zero) state_in = ST_FINISH;
            else if (status.reject) state_in = ST_MIX;
            else state_in = ST_MOD;
         end
         ST_MOD:        state_in = ST_MOD_WAIT;
         ST_MOD_WAIT:   if (status.div_done) state_in = ST_FINISH;
         ST_FINISH:     state_in = ST_OUT;
         ST_OUT:        if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load_req  = accept;
            cmd.load_seed = accept && (kind_type'(req_kind) == KIND_SEED);
         end
         ST_LIMIT:  cmd.div_limit = !status.span_zero;
         ST_MIX:    cmd.mix_start = 1'b1;
         ST_MOD:    cmd.div_sample = 1'b1;
         ST_FINISH: cmd.set_result = 1'b1;
         ST_OUT:    cmd.out_valid_set = !rsp_valid_ff || rsp_tready;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.out_valid_set) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== sv/splitmix_bounded_random_unit.sv =====
// Top level of the SplitMix64 bounded random unit.
// Each draw request advances a 64-bit SplitMix64 state and returns one result;
// a seed load sets the state instead. A fraction or bit draw runs the staged
// mixer of nine steps, each 64-bit multiply built from three 32x32 partial
// products. An integer draw runs a bit-serial divider twice (rejection limit,
// then sample mod span) and draws again for each rejected sample; a zero span
// skips both divisions. The result sits in an output register, so a new request
// is taken in the cycle after the result has been handed over to that register.
module splitmix_bounded_random_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // kind[1:0], range_start[65:2], range_end[129:66], seed_value[193:130]
   input  logic [199:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // value[63:0]
   output logic [63:0]   rsp_tdata
);
   import smbr_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [63:0] result;
   logic [63:0] rsp_ff;

   smbr_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .req_kind   (req_tdata[1:0]),
      .status     (status),
      .cmd        (cmd)
   );

   smbr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata[193:0]),
      .result    (result)
   );

   // output register loaded on each finished item
   always_ff @(posedge clock) begin
      if (cmd.out_valid_set) rsp_ff <= result;
   end

   assign rsp_tdata = rsp_ff;

endmodule
